// File: rtl/bmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_pkg: shared types and constants of the 3x3 morphology chain
// Row width, register indexes, operation codes, queue and stage words, and
// the 3x3 window function used by every stage.
// ----------------------------------------------------------------------------
package bmc_pkg;

	localparam int ROW_W       = 64;  // widest row the block takes
	localparam int WIDTH_W     = 7;   // image_width register
	localparam int MODE_W      = 2;   // mode register
	localparam int NUM_STAGES  = 4;   // stages of the chain
	localparam int QDEPTH      = 2;   // front-to-back queue, power of two
	localparam int QPTR_W      = $clog2(QDEPTH);

	// register indexes on the config port
	localparam logic [0:0] REG_WIDTH = 1'd0;
	localparam logic [0:0] REG_MODE  = 1'd1;

	// mode register codes
	localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CHAIN  = 2'd2;

	typedef enum logic [1:0] {
		OP_ERODE  = 2'd0,
		OP_DILATE = 2'd1,
		OP_CHAIN  = 2'd2
	} op_t;

	// one classified row in the queue
	typedef struct packed {
		logic [ROW_W-1:0] row;
		op_t              op;
		logic             last;
	} word_t;

	// flags that travel with a row between stages
	typedef struct packed {
		logic last;     // flush row of the frame
		logic run_end;  // final row caused by its input word
		logic chain;    // row belongs to the four-stage chain
	} row_tag_t;

	// 3x3 window for the middle row b; a above, c below, m the width mask
	function automatic logic [ROW_W-1:0] window(
		input logic             dil,
		input logic [ROW_W-1:0] a,
		input logic [ROW_W-1:0] b,
		input logic [ROW_W-1:0] c,
		input logic [ROW_W-1:0] m
	);
		logic [ROW_W-1:0] v;
		logic [ROW_W-1:0] r;
		if (dil) begin
			v = (a | b | c) & m;
			r = v | (v << 1) | (v >> 1);
		end else begin
			v = a & b & c & m;
			r = v & (v << 1) & (v >> 1);
		end
		return r & m;
	endfunction

endpackage
`default_nettype wire

// File: rtl/bmc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_front: input acceptance and classification
// Builds the width mask, masks the incoming row and tags it with the
// operation picked by the mode register before it enters the queue.
// ----------------------------------------------------------------------------
module bmc_front import bmc_pkg::*; (
	input  wire logic               row_valid,
	output logic                    row_ready,
	input  wire logic [ROW_W-1:0]   row_bits,
	input  wire logic               last_row,
	input  wire logic [WIDTH_W-1:0] image_width,
	input  wire logic [MODE_W-1:0]  mode,
	input  wire logic               q_full,
	output logic                    q_push,
	output word_t                   q_word,
	output logic [ROW_W-1:0]        row_mask
);

	op_t op;

	// column c is in use when c < width; widths past the row saturate
	always_comb begin
		for (int c = 0; c < ROW_W; c++) begin
			row_mask[c] = ({1'b0, image_width} > (WIDTH_W + 1)'(c));
		end
	end

	always_comb begin
		case (mode)
			MODE_ERODE:  op = OP_ERODE;
			MODE_DILATE: op = OP_DILATE;
			MODE_CHAIN:  op = OP_CHAIN;
			default:     op = OP_CHAIN;  // unused code runs the chain
		endcase
	end

	assign row_ready   = !q_full;
	assign q_push      = row_valid && row_ready;
	assign q_word.row  = row_bits & row_mask;
	assign q_word.op   = op;
	assign q_word.last = last_row;

endmodule
`default_nettype wire

// File: rtl/bmc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_queue: short word queue between front and back
// Two-entry FIFO; the head is shown combinationally to the back.
// ----------------------------------------------------------------------------
module bmc_queue import bmc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire word_t push_word,
	output logic       full,
	input  wire logic  pop,
	output logic       head_valid,
	output word_t      head_word
);

	word_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;

	assign full       = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_word  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

endmodule
`default_nettype wire

// File: rtl/bmc_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_stage: one 3x3 erosion or dilation stage
// Holds the row above and the current row, emits the processed current row
// when the next one arrives, and a flush row after the frame's last row.
// ----------------------------------------------------------------------------
module bmc_stage import bmc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             dilate,
	input  wire logic [ROW_W-1:0] mask,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [ROW_W-1:0] in_row,
	input  wire row_tag_t         in_tag,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [ROW_W-1:0]      out_row,
	output row_tag_t              out_tag
);

	logic [ROW_W-1:0] prev_q;
	logic [ROW_W-1:0] cur_q;
	logic             held_q;
	logic             flush_q;
	logic             flush_dil_q;
	row_tag_t         flush_tag_q;
	logic             out_valid_q;
	logic [ROW_W-1:0] out_row_q;
	row_tag_t         out_tag_q;

	logic             slot_free;
	logic             take;
	logic             emit_flush;
	logic [ROW_W-1:0] x;
	logic [ROW_W-1:0] win_next;
	logic [ROW_W-1:0] win_first;
	logic [ROW_W-1:0] win_flush;

	assign slot_free  = !out_valid_q || out_ready;
	assign in_ready   = !flush_q && slot_free;
	assign take       = in_valid && in_ready;
	assign emit_flush = flush_q && slot_free;
	assign x          = in_row & mask;

	assign win_next  = window(dilate, prev_q, cur_q, x, mask);
	assign win_first = window(dilate, '0, x, '0, mask);
	assign win_flush = window(flush_dil_q, prev_q, cur_q, '0, mask);

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_tag   = out_tag_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 1'b0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (held_q) begin
					out_valid_q <= 1'b1;
					flush_q     <= in_tag.last;
				end else begin
					held_q      <= !in_tag.last;
					out_valid_q <= in_tag.last || (out_valid_q && !out_ready);
				end
			end else if (emit_flush) begin
				out_valid_q <= 1'b1;
				flush_q     <= 1'b0;
				held_q      <= 1'b0;
			end
		end
	end

	// row data
	always_ff @(posedge clk) begin
		if (take) begin
			cur_q       <= x;
			flush_dil_q <= dilate;
			flush_tag_q <= in_tag;
			if (held_q) begin
				prev_q            <= cur_q;
				out_row_q         <= win_next;
				out_tag_q.last    <= 1'b0;
				out_tag_q.run_end <= in_tag.run_end && !in_tag.last;
				out_tag_q.chain   <= in_tag.chain;
			end else begin
				prev_q <= '0;
				if (in_tag.last) begin
					out_row_q <= win_first;
					out_tag_q <= in_tag;
				end
			end
		end else if (emit_flush) begin
			out_row_q <= win_flush;
			out_tag_q <= flush_tag_q;
		end
	end

endmodule
`default_nettype wire

// File: rtl/bmc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_back: stage chain
// Pops classified rows, runs them through stage 0 alone or through all four
// stages (erode, dilate, erode, dilate), and presents the final rows.
// ----------------------------------------------------------------------------
module bmc_back import bmc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [ROW_W-1:0] mask,
	input  wire logic             q_valid,
	input  wire word_t            q_word,
	output logic                  q_pop,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output logic [ROW_W-1:0]      res_row,
	output row_tag_t              res_tag
);

	logic             st_dil       [NUM_STAGES];
	logic             st_in_valid  [NUM_STAGES];
	logic             st_in_ready  [NUM_STAGES];
	logic [ROW_W-1:0] st_in_row    [NUM_STAGES];
	row_tag_t         st_in_tag    [NUM_STAGES];
	logic             st_out_valid [NUM_STAGES];
	logic             st_out_ready [NUM_STAGES];
	logic [ROW_W-1:0] st_out_row   [NUM_STAGES];
	row_tag_t         st_out_tag   [NUM_STAGES];
	logic             single_out;

	// stage 0 takes the queue head; odd stages of the chain dilate
	always_comb begin
		st_dil[0]              = (q_word.op == OP_DILATE);
		st_in_valid[0]         = q_valid;
		st_in_row[0]           = q_word.row;
		st_in_tag[0].last      = q_word.last;
		st_in_tag[0].run_end   = 1'b1;
		st_in_tag[0].chain     = (q_word.op == OP_CHAIN);
		q_pop                  = q_valid && st_in_ready[0];

		single_out = st_out_valid[0] && !st_out_tag[0].chain;

		st_in_valid[1]  = st_out_valid[0] && st_out_tag[0].chain;
		st_out_ready[0] = st_out_tag[0].chain ? st_in_ready[1] : res_ready;
		for (int s = 1; s < NUM_STAGES; s++) begin
			st_dil[s]    = s[0];
			st_in_row[s] = st_out_row[s-1];
			st_in_tag[s] = st_out_tag[s-1];
		end
		for (int s = 2; s < NUM_STAGES; s++) begin
			st_in_valid[s]    = st_out_valid[s-1];
			st_out_ready[s-1] = st_in_ready[s];
		end
		st_out_ready[NUM_STAGES-1] = res_ready;

		if (single_out) begin
			res_valid = 1'b1;
			res_row   = st_out_row[0];
			res_tag   = st_out_tag[0];
		end else begin
			res_valid = st_out_valid[NUM_STAGES-1];
			res_row   = st_out_row[NUM_STAGES-1];
			res_tag   = st_out_tag[NUM_STAGES-1];
		end
	end

	for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
		bmc_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.dilate    (st_dil[s]),
			.mask      (mask),
			.in_valid  (st_in_valid[s]),
			.in_ready  (st_in_ready[s]),
			.in_row    (st_in_row[s]),
			.in_tag    (st_in_tag[s]),
			.out_valid (st_out_valid[s]),
			.out_ready (st_out_ready[s]),
			.out_row   (st_out_row[s]),
			.out_tag   (st_out_tag[s])
		);
	end

endmodule
`default_nettype wire

// File: rtl/binary_morphology_chain_3x3.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_morphology_chain_3x3: streaming 3x3 binary erosion / dilation
//
// Input channel (row_valid/row_ready) takes one packed image row per word,
// bit c = column c, with last_row on the frame's final row. Result channel
// (res_valid/res_ready) returns processed rows with frame_end on the frame's
// final row and run_end on the last result caused by an input word.
// APB port: image_width at 0x0, mode at 0x4 (0 erode, 1 dilate, 2 chain of
// erode, dilate, erode, dilate). Write registers only while idle.
// Each stage lags one row, so a row's result leaves when the next row enters;
// a last row flushes every stage and can cause up to five results.
// A result passes the queue and then one output register per stage that
// it runs through. Ordinary rows are taken at one word per cycle while the
// receiver keeps up; each stage's single output register emits one row per
// cycle, so a last row in chain mode holds the input while the flush rows
// drain.
// A stalled receiver backs up through the stage registers into the two-word
// queue, after which row_ready drops. Reset empties queue and stages and
// restores width 64, mode 2.
// ----------------------------------------------------------------------------
module binary_morphology_chain_3x3 import bmc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// APB configuration
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready,
	// row input
	input  wire logic             row_valid,
	output logic                  row_ready,
	input  wire logic [ROW_W-1:0] row_bits,
	input  wire logic             last_row,
	// result output
	output logic                  res_valid,
	input  wire logic             res_ready,
	output logic [ROW_W-1:0]      out_row_bits,
	output logic                  frame_end,
	output logic                  run_end
);

	logic [WIDTH_W-1:0] width_q;
	logic [MODE_W-1:0]  mode_q;
	logic [0:0]         reg_idx;
	logic               cfg_wr;

	logic               q_full;
	logic               q_push;
	word_t              q_in_word;
	logic               q_valid;
	word_t              q_head;
	logic               q_pop;
	logic [ROW_W-1:0]   row_mask;
	row_tag_t           res_tag;

	// ---- configuration registers ----
	assign pready  = 1'b1;
	assign reg_idx = paddr[2:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_W'(64);
			mode_q  <= MODE_CHAIN;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WIDTH: width_q <= pwdata[WIDTH_W-1:0];
				REG_MODE:  mode_q  <= pwdata[MODE_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WIDTH: prdata = {{(32 - WIDTH_W){1'b0}}, width_q};
			REG_MODE:  prdata = {{(32 - MODE_W){1'b0}}, mode_q};
			default:   prdata = '0;
		endcase
	end

	// ---- front: mask and classify incoming rows ----
	bmc_front u_front (
		.row_valid   (row_valid),
		.row_ready   (row_ready),
		.row_bits    (row_bits),
		.last_row    (last_row),
		.image_width (width_q),
		.mode        (mode_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_word      (q_in_word),
		.row_mask    (row_mask)
	);

	// ---- queue decouples acceptance from the stage chain ----
	bmc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_word  (q_in_word),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_word  (q_head)
	);

	// ---- back: stage chain and result selection ----
	// mask comes straight from the width register; the user must keep it
	// stable while any row is in flight, the block does not enforce this
	bmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mask      (row_mask),
		.q_valid   (q_valid),
		.q_word    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_row   (out_row_bits),
		.res_tag   (res_tag)
	);

	assign frame_end = res_tag.last;
	assign run_end   = res_tag.run_end;

`ifndef NO_ASSERTIONS
	// the frame's flush row is always the final result of its word
	a_frame_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!frame_end || run_end))
		else $error("frame_end without run_end");

	// nothing shows up beyond the configured width
	a_out_masked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((out_row_bits & ~row_mask) == '0))
		else $error("result bits beyond image width");

	// a full queue that was not drained keeps the input stalled
	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && !q_pop) |=> !row_ready)
		else $error("input taken while queue full");
`endif

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 3x3 binary morphology chain
// Drives image rows through a valid/ready driver, programs width and mode
// over APB between phases, and checks every result row against a local
// row-by-row model of the erode/dilate stages kept in step with the block.
// ----------------------------------------------------------------------------
module tb_top;
	import bmc_pkg::*;

	localparam int CLK_HALF   = 5;
	localparam int SETTLE     = 10;      // settle wait after drain, covers rows with no result
	localparam int HOLD_LEN   = 80;      // long receiver hold-off
	localparam int LIMIT      = 300000;  // watchdog, cycles
	localparam int RAND_ITEMS = 85;

	// one row offered to the block
	typedef struct {
		logic [ROW_W-1:0] bits;
		logic             last;
	} row_word_t;

	// one result row the block must return
	typedef struct {
		logic [ROW_W-1:0] bits;
		logic             fe;
		logic             re;
	} res_word_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             psel      = 1'b0;
	logic             penable   = 1'b0;
	logic             pwrite    = 1'b0;
	logic [2:0]       paddr     = '0;
	logic [31:0]      pwdata    = '0;
	logic [31:0]      prdata;
	logic             pready;
	logic             row_valid = 1'b0;
	logic             row_ready;
	logic [ROW_W-1:0] row_bits  = '0;
	logic             last_row  = 1'b0;
	logic             res_valid;
	logic             res_ready = 1'b0;
	logic [ROW_W-1:0] out_row_bits;
	logic             frame_end;
	logic             run_end;

	binary_morphology_chain_3x3 u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.row_valid    (row_valid),
		.row_ready    (row_ready),
		.row_bits     (row_bits),
		.last_row     (last_row),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.out_row_bits (out_row_bits),
		.frame_end    (frame_end),
		.run_end      (run_end)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------
	// Row model: a copy of the registers and of the two rows each stage
	// holds (above, current). Updated once per accepted input word.
	// ------------------------------------------------------------------
	logic [WIDTH_W-1:0] cfg_width = 7'd64;
	logic [MODE_W-1:0]  cfg_mode  = MODE_CHAIN;
	logic [ROW_W-1:0]   stage_mem [2*NUM_STAGES] = '{default: '0};
	logic [1:0]         stage_cnt [NUM_STAGES]   = '{default: '0};
	logic [ROW_W-1:0]   stage_emit [$];          // rows leaving the stage in work
	res_word_t          due_rows [$];            // results still owed by the block
	row_word_t          pend_rows [$];           // words waiting for the driver

	// columns past the width are dead; widths above 64 clamp to 64
	function automatic logic [ROW_W-1:0] live_cols();
		int w;
		w = (cfg_width > ROW_W) ? ROW_W : int'(cfg_width);
		return (w >= ROW_W) ? '1 : ((64'd1 << w) - 64'd1);
	endfunction

	// 3x3 neighborhood for row b: vertical combine, then left/center/right
	function automatic logic [ROW_W-1:0] nbhd3(bit grow, logic [ROW_W-1:0] a,
		logic [ROW_W-1:0] b, logic [ROW_W-1:0] c, logic [ROW_W-1:0] m);
		logic [ROW_W-1:0] v;
		logic [ROW_W-1:0] r;
		logic             lf;
		logic             rt;
		v = grow ? ((a | b | c) & m) : (a & b & c & m);
		for (int col = 0; col < ROW_W; col++) begin
			lf = (col > 0) ? v[col-1] : 1'b0;        // off-frame reads as 0
			rt = (col < ROW_W-1) ? v[col+1] : 1'b0;
			r[col] = grow ? (lf | v[col] | rt) : (lf & v[col] & rt);
		end
		return r & m;
	endfunction

	// push one row into stage s; a held row is released when the next one
	// enters, and a flush row drains the stage against an all-zero row below
	function automatic void stage_advance(int s, bit grow, logic [ROW_W-1:0] x,
		bit flush, logic [ROW_W-1:0] m);
		x = x & m;
		if (stage_cnt[s] != 2'd0) begin
			stage_emit.push_back(nbhd3(grow, stage_mem[2*s], stage_mem[2*s+1], x, m));
			stage_mem[2*s]   = stage_mem[2*s+1];
			stage_mem[2*s+1] = x;
			stage_cnt[s]     = 2'd2;
		end else begin
			stage_mem[2*s]   = '0;
			stage_mem[2*s+1] = x;
			stage_cnt[s]     = 2'd1;
		end
		if (flush) begin
			stage_emit.push_back(nbhd3(grow, stage_mem[2*s], stage_mem[2*s+1], '0, m));
			stage_mem[2*s]   = '0;
			stage_mem[2*s+1] = '0;
			stage_cnt[s]     = 2'd0;
		end
	endfunction

	// expected results of one accepted row; mode 3 runs as the full chain,
	// stages the current mode skips keep whatever they hold
	function automatic void morph_predict(logic [ROW_W-1:0] bits, bit lst);
		logic [ROW_W-1:0] m;
		logic [ROW_W-1:0] flow [$];
		int               n_st;
		bit               grow;
		res_word_t        r;
		m    = live_cols();
		n_st = (cfg_mode == MODE_ERODE || cfg_mode == MODE_DILATE) ? 1 : NUM_STAGES;
		flow = {};
		flow.push_back(bits);
		for (int s = 0; s < n_st; s++) begin
			if (cfg_mode == MODE_ERODE)       grow = 1'b0;
			else if (cfg_mode == MODE_DILATE) grow = 1'b1;
			else                              grow = s[0];   // E, D, E, D
			stage_emit = {};
			foreach (flow[k])
				stage_advance(s, grow, flow[k], lst && (k == flow.size() - 1), m);
			flow = stage_emit;
		end
		foreach (flow[k]) begin
			r.bits = flow[k] & m;
			r.re   = (k == flow.size() - 1);
			r.fe   = lst && r.re;
			due_rows.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: one word per handshake, ~6% random gaps unless steady
	// ------------------------------------------------------------------
	bit        steady   = 1'b0;
	row_word_t next_w;

	always @(posedge clk) begin
		if (arst_n) begin
			if (row_valid && row_ready)
				morph_predict(row_bits, last_row);
			// slot free: either nothing offered or the offer just went in
			if (!row_valid || row_ready) begin
				if (pend_rows.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
					next_w    = pend_rows.pop_front();
					row_valid <= 1'b1;
					row_bits  <= next_w.bits;
					last_row  <= next_w.last;
				end else begin
					row_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each accepted result against the oldest one owed;
	// ready drops ~6% at random, plus one long hold-off when armed
	// ------------------------------------------------------------------
	bit        hold_arm  = 1'b0;
	bit        hold_done = 1'b0;
	int        hold_cnt  = 0;
	int        errs      = 0;
	res_word_t head_w;

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (due_rows.size() == 0) begin
					$error("result with none owed: out_row_bits=%h frame_end=%0b run_end=%0b",
						out_row_bits, frame_end, run_end);
					errs = errs + 1;
				end else begin
					head_w = due_rows.pop_front();
					if (out_row_bits !== head_w.bits) begin
						$error("out_row_bits: expected %h, got %h", head_w.bits, out_row_bits);
						errs = errs + 1;
					end
					if (frame_end !== head_w.fe) begin
						$error("frame_end: expected %0b, got %0b", head_w.fe, frame_end);
						errs = errs + 1;
					end
					if (run_end !== head_w.re) begin
						$error("run_end: expected %0b, got %0b", head_w.re, run_end);
						errs = errs + 1;
					end
				end
			end
			if (hold_arm && !hold_done) begin
				res_ready <= 1'b0;
				hold_cnt  <= hold_cnt + 1;
				if (hold_cnt == HOLD_LEN)
					hold_done <= 1'b1;
			end else begin
				res_ready <= steady || ($urandom_range(99) >= 6);
			end
		end
	end

	// watchdog
	int cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// APB write: setup, then access; register takes the value at the
	// access edge (pready is tied high)
	task automatic reg_write(logic [0:0] idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_WIDTH) cfg_width = val[WIDTH_W-1:0];
		else                  cfg_mode  = val[MODE_W-1:0];
	endtask

	// sender stops until every owed result is back, then lets rows that
	// owe nothing clear the pipe
	task automatic drain();
		do @(posedge clk);
		while (pend_rows.size() != 0 || row_valid || due_rows.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_row(logic [ROW_W-1:0] bits, bit lst);
		row_word_t w;
		w.bits = bits;
		w.last = lst;
		pend_rows.push_back(w);
	endtask

	// n rows; the last carries last_row unless the frame is left open
	task automatic queue_frame(int n, bit close_it);
		for (int i = 0; i < n; i++)
			queue_row(row_mix(), close_it && (i == n - 1));
	endtask

	// mostly dense rows so erosion leaves something, plus plain random
	function automatic logic [ROW_W-1:0] row_mix();
		logic [ROW_W-1:0] a;
		logic [ROW_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(6))
			0: return a;
			1: return a | b;
			2: return ~(a & b & {$urandom, $urandom});
			3: return a & b;
			4: return '1;
			5: return '0;
			default: return ~(64'd1 << $urandom_range(63));
		endcase
	endfunction

	function automatic logic [31:0] width_pick();
		case ($urandom_range(9))
			0: return $urandom_range(0, 2);        // degenerate widths
			1: return $urandom_range(65, 127);     // clamps to 64
			2: return 64;
			3: return 3;
			default: return $urandom_range(3, 64);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	int rand_sent = 0;
	int phase_no  = 0;
	int n_rows;

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// erosion alone: solid block, border columns and rows cleared
		reg_write(REG_WIDTH, 32'd64);
		reg_write(REG_MODE, MODE_ERODE);
		queue_row('1, 1'b0);
		queue_row('1, 1'b0);
		queue_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
		queue_row('1, 1'b1);
		drain();

		// dilation alone: single-row frame with pixels on both edge columns,
		// then a frame whose first row is empty
		reg_write(REG_MODE, MODE_DILATE);
		queue_row(64'h8000_0000_0000_0001, 1'b1);
		queue_row('0, 1'b0);
		queue_row(64'h0000_0001_0000_0000, 1'b0);
		queue_row('0, 1'b1);
		drain();

		// width 3 through the chain; upper bits must be ignored
		reg_write(REG_WIDTH, 32'd3);
		reg_write(REG_MODE, MODE_CHAIN);
		queue_row('1, 1'b0);
		queue_row('1, 1'b0);
		queue_row('1, 1'b0);
		queue_row('1, 1'b1);
		drain();

		// width above range clamps; unused mode code runs the chain
		reg_write(REG_WIDTH, 32'd127);
		reg_write(REG_MODE, 32'd3);
		repeat (4) queue_row('1, 1'b0);
		queue_row('1, 1'b1);
		drain();

		// zero width gives empty rows; width 2 dilation
		reg_write(REG_WIDTH, 32'd0);
		reg_write(REG_MODE, MODE_ERODE);
		queue_row('1, 1'b0);
		queue_row('1, 1'b1);
		drain();
		reg_write(REG_WIDTH, 32'd2);
		reg_write(REG_MODE, MODE_DILATE);
		queue_row('1, 1'b1);
		drain();

		// mode change inside a frame: later stages keep their rows while
		// erosion alone runs, then the chain resumes with them
		reg_write(REG_WIDTH, 32'd64);
		reg_write(REG_MODE, MODE_CHAIN);
		queue_row('1, 1'b0);
		queue_row('1, 1'b0);
		drain();
		reg_write(REG_MODE, MODE_ERODE);
		queue_row('1, 1'b0);
		queue_row('1, 1'b1);
		drain();
		reg_write(REG_MODE, MODE_CHAIN);
		queue_row('1, 1'b1);
		drain();

		// random phases: fresh settings, a few frames, sometimes left open
		while (rand_sent < RAND_ITEMS) begin
			phase_no = phase_no + 1;
			reg_write(REG_WIDTH, width_pick());
			if (phase_no == 1) begin
				// long receiver hold-off while the sender keeps offering
				reg_write(REG_MODE, MODE_CHAIN);
				@(posedge clk);
				hold_arm <= 1'b1;
				queue_frame(14, 1'b1);
				rand_sent = rand_sent + 14;
			end else if (phase_no == 3) begin
				// no gaps on either side for a stretch
				reg_write(REG_MODE, $urandom_range(0, 3));
				@(posedge clk);
				steady <= 1'b1;
				queue_frame(8, 1'b1);
				queue_frame(8, 1'b1);
				rand_sent = rand_sent + 16;
			end else begin
				reg_write(REG_MODE, $urandom_range(0, 3));
				repeat ($urandom_range(1, 3)) begin
					n_rows = $urandom_range(1, 6);
					queue_frame(n_rows, $urandom_range(5) != 0);
					rand_sent = rand_sent + n_rows;
				end
			end
			drain();
			steady <= 1'b0;
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (errs == 0) begin
			$display("CHECK OK");
			$finish;
		end else begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

// File: binary_morphology_chain_3x3.f
rtl/bmc_pkg.sv
rtl/bmc_front.sv
rtl/bmc_queue.sv
rtl/bmc_stage.sv
rtl/bmc_back.sv
rtl/binary_morphology_chain_3x3.sv
sim/tb_top.sv
